### hdl/ptmt_pkg.sv
// Shared types and constants of the packet target match table.
package ptmt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 16;

   // Request field widths.
   localparam int REQ_TYPE_W  = 2;
   localparam int ENTRY_IDX_W = 4;
   localparam int HOST_W      = 32;
   localparam int PORT_W      = 16;

   // Request type codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PORT  = 2'd1;
   localparam int unsigned REQ_SRCIP_CODE = 2;
   localparam logic [REQ_TYPE_W-1:0] REQ_SRCIP = REQ_TYPE_W'(REQ_SRCIP_CODE);
   localparam logic [REQ_TYPE_W-1:0] REQ_NAT   = 2'd3;

   // Queue depths.
   localparam int FRONT_DEPTH = 4;
   localparam int RSP_DEPTH   = 2;

   // Classified command handed from the front queue to the table.
   // For a write, host and ports are the entry data; for a lookup they are the
   // search key and the chk_* bits select which of them take part.
   typedef struct packed {
      logic                   is_write;
      logic [ENTRY_IDX_W-1:0] idx;
      logic                   wr_valid;
      logic [HOST_W-1:0]      host;
      logic [PORT_W-1:0]      dport;
      logic [PORT_W-1:0]      sport;
      logic                   chk_host;
      logic                   chk_dport;
      logic                   chk_sport;
   } ptmt_cmd_type;

endpackage

### hdl/packet_target_match_table_top.sv
// Top level of the packet target match table.
//
// Exact-match packet classifier over a table of TABLE_DEPTH target entries,
// each a valid bit, a 32-bit host address and 16-bit destination and source
// ports. A write request (type 0) loads or clears the slot named by
// req_entry_index and returns a result of 0; writes to a slot index beyond
// the table are dropped. A lookup returns 1 when any valid slot fits: port
// mode (1) compares the destination port, source ip mode (2) compares the
// packet source address with the slot host, nat mode (3) needs destination
// address, destination port and source port all equal. Every request yields
// exactly one result, in request order. The table is empty after reset with
// no clearing pass. Requests enter a four-deep queue (push/full) where they
// are classified into table commands; the table stage then compares all
// slots in parallel, one command per cycle while the result queue has room,
// and registers the per-slot hit vector, which is OR-reduced into a two-deep
// result queue (empty/pop). Sustained rate is one request per cycle while
// results are popped, set by the single table compare stage; a result is
// held in the front queue, the hit register and the result queue in turn
// before it appears on the result ports. A lookup sees every write accepted before it.
module packet_target_match_table_top
   import ptmt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   push,
   output logic                   full,
   input  logic [REQ_TYPE_W-1:0]  req_type,
   input  logic [ENTRY_IDX_W-1:0] req_entry_index,
   input  logic                   req_entry_valid,
   input  logic [HOST_W-1:0]      req_target_host,
   input  logic [PORT_W-1:0]      req_target_dst_port,
   input  logic [PORT_W-1:0]      req_target_src_port,
   input  logic [HOST_W-1:0]      req_pkt_src_ip,
   input  logic [HOST_W-1:0]      req_pkt_dst_ip,
   input  logic [PORT_W-1:0]      req_pkt_dst_port,
   input  logic [PORT_W-1:0]      req_pkt_src_port,
   // result channel
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_match
);

   ptmt_cmd_type cmd;
   logic         cmd_avail;
   logic         cmd_take;
   logic         res_valid;
   logic         res_match;
   logic         res_ready;

   // Classify and buffer requests.
   ptmt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_type            (req_type),
      .req_entry_index     (req_entry_index),
      .req_entry_valid     (req_entry_valid),
      .req_target_host     (req_target_host),
      .req_target_dst_port (req_target_dst_port),
      .req_target_src_port (req_target_src_port),
      .req_pkt_src_ip      (req_pkt_src_ip),
      .req_pkt_dst_ip      (req_pkt_dst_ip),
      .req_pkt_dst_port    (req_pkt_dst_port),
      .req_pkt_src_port    (req_pkt_src_port),
      .cmd                 (cmd),
      .cmd_avail           (cmd_avail),
      .cmd_take            (cmd_take)
   );

   // Update or search the table, one command per cycle while the result queue has room.
   ptmt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_avail (cmd_avail),
      .cmd_take  (cmd_take),
      .res_valid (res_valid),
      .res_match (res_match),
      .res_ready (res_ready)
   );

   // Hold results until popped.
   ptmt_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_match (res_match),
      .res_ready (res_ready),
      .empty     (empty),
      .rsp_match (rsp_match),
      .pop       (pop)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not cleared by reset");
`endif

endmodule

### hdl/ptmt_front.sv
// Front end: classifies incoming requests and queues them as table commands.
module ptmt_front
   import ptmt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [REQ_TYPE_W-1:0]  req_type,
   input  logic [ENTRY_IDX_W-1:0] req_entry_index,
   input  logic                   req_entry_valid,
   input  logic [HOST_W-1:0]      req_target_host,
   input  logic [PORT_W-1:0]      req_target_dst_port,
   input  logic [PORT_W-1:0]      req_target_src_port,
   input  logic [HOST_W-1:0]      req_pkt_src_ip,
   input  logic [HOST_W-1:0]      req_pkt_dst_ip,
   input  logic [PORT_W-1:0]      req_pkt_dst_port,
   input  logic [PORT_W-1:0]      req_pkt_src_port,
   output ptmt_cmd_type           cmd,
   output logic                   cmd_avail,
   input  logic                   cmd_take
);

   localparam int FQ_PTR_W = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
   localparam int FQ_CNT_W = $clog2(FRONT_DEPTH + 1);

   ptmt_cmd_type          mem_ff [FRONT_DEPTH];
   logic [FQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_W-1:0]   count_ff, count_in;
   ptmt_cmd_type          cmd_new;
   logic                  push_acc;
   logic                  pop_acc;

   // Classify: a lookup carries its key and the mask of fields it compares.
   always_comb begin
      cmd_new              = '0;
      cmd_new.idx          = req_entry_index;
      cmd_new.wr_valid     = req_entry_valid;
      cmd_new.dport        = req_pkt_dst_port;
      cmd_new.sport        = req_pkt_src_port;
      unique case (req_type)
         REQ_WRITE: begin
            cmd_new.is_write = 1'b1;
            cmd_new.host     = req_target_host;
            cmd_new.dport    = req_target_dst_port;
            cmd_new.sport    = req_target_src_port;
         end
         REQ_PORT: begin
            cmd_new.chk_dport = 1'b1;
         end
         REQ_SRCIP: begin
            cmd_new.host     = req_pkt_src_ip;
            cmd_new.chk_host = 1'b1;
         end
         REQ_NAT: begin
            cmd_new.host      = req_pkt_dst_ip;
            cmd_new.chk_host  = 1'b1;
            cmd_new.chk_dport = 1'b1;
            cmd_new.chk_sport = 1'b1;
         end
      endcase
   end

   assign full      = (count_ff == FQ_CNT_W'(FRONT_DEPTH));
   assign cmd_avail = (count_ff != '0);
   assign push_acc  = push & ~full;
   assign pop_acc   = cmd_take & cmd_avail;
   assign cmd       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_acc) begin
         wr_ptr_in = (wr_ptr_ff == FQ_PTR_W'(FRONT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_acc) begin
         rd_ptr_in = (rd_ptr_ff == FQ_PTR_W'(FRONT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + FQ_CNT_W'(push_acc) - FQ_CNT_W'(pop_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_acc) begin
         mem_ff[wr_ptr_ff] <= cmd_new;
      end
   end

`ifndef SYNTHESIS
   // An accepted request with nothing leaving must leave a command waiting.
   a_push_not_lost: assert property (@(posedge clock) disable iff (reset)
      (push_acc && !pop_acc) |=> cmd_avail)
      else $error("front queue lost an accepted request");
`endif

endmodule

### hdl/ptmt_back.sv
// Back end: target table storage, per-slot compare and match reduction.
module ptmt_back
   import ptmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ptmt_cmd_type cmd,
   input  logic         cmd_avail,
   output logic         cmd_take,
   output logic         res_valid,
   output logic         res_match,
   input  logic         res_ready
);

   logic                   slot_valid_ff [TABLE_DEPTH];
   logic [HOST_W-1:0]      slot_host_ff  [TABLE_DEPTH];
   logic [PORT_W-1:0]      slot_dport_ff [TABLE_DEPTH];
   logic [PORT_W-1:0]      slot_sport_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] hit_ff, hit_in;
   logic                   hv_ff, hv_in;
   logic                   load;
   logic                   wr_en;

   // Take a command when the hit register is free or drains this cycle.
   assign load     = cmd_avail & (~hv_ff | res_ready);
   assign cmd_take = load;
   assign wr_en    = load & cmd.is_write;

   // One comparator lane per slot; a write reports no hit.
   always_comb begin
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         hit_in[s] = slot_valid_ff[s] & ~cmd.is_write
                   & (~cmd.chk_host  | (cmd.host  == slot_host_ff[s]))
                   & (~cmd.chk_dport | (cmd.dport == slot_dport_ff[s]))
                   & (~cmd.chk_sport | (cmd.sport == slot_sport_ff[s]));
      end
      hv_in = load | (hv_ff & ~res_ready);
   end

   assign res_valid = hv_ff;
   assign res_match = |hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= 1'b0;
         for (int s = 0; s < TABLE_DEPTH; s++) begin
            slot_valid_ff[s] <= 1'b0;
         end
      end else begin
         hv_ff <= hv_in;
         for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (wr_en && (32'(cmd.idx) == s)) begin
               slot_valid_ff[s] <= cmd.wr_valid;
            end
         end
      end
   end

   // Slot data and hits carry no reset; writes beyond the table match no slot.
   always_ff @(posedge clock) begin
      if (load) begin
         hit_ff <= hit_in;
      end
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         if (wr_en && (32'(cmd.idx) == s)) begin
            slot_host_ff[s]  <= cmd.host;
            slot_dport_ff[s] <= cmd.dport;
            slot_sport_ff[s] <= cmd.sport;
         end
      end
   end

`ifndef SYNTHESIS
   a_write_no_match: assert property (@(posedge clock) disable iff (reset)
      (load && cmd.is_write) |=> (hv_ff && (hit_ff == '0)))
      else $error("write request produced a hit");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (hv_ff && !res_ready) |=> (hv_ff && $stable(hit_ff)))
      else $error("stalled result changed");
`endif

endmodule

### hdl/ptmt_rsp_queue.sv
// Result queue holding match bits until the consumer pops them.
module ptmt_rsp_queue
   import ptmt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic res_valid,
   input  logic res_match,
   output logic res_ready,
   output logic empty,
   output logic rsp_match,
   input  logic pop
);

   localparam int RQ_PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int RQ_CNT_W = $clog2(RSP_DEPTH + 1);

   logic                mem_ff [RSP_DEPTH];
   logic [RQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0] count_ff, count_in;
   logic                push_acc;
   logic                pop_acc;

   assign res_ready = (count_ff != RQ_CNT_W'(RSP_DEPTH));
   assign empty     = (count_ff == '0);
   assign push_acc  = res_valid & res_ready;
   assign pop_acc   = pop & ~empty;
   assign rsp_match = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_acc) begin
         wr_ptr_in = (wr_ptr_ff == RQ_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_acc) begin
         rd_ptr_in = (rd_ptr_ff == RQ_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + RQ_CNT_W'(push_acc) - RQ_CNT_W'(pop_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_acc) begin
         mem_ff[wr_ptr_ff] <= res_match;
      end
   end

endmodule
